@@ design/qbbr_pkg.sv @@
// shared widths, types and constants for the rotated box bounds block
package qbbr_pkg;

  // item and register widths
  localparam int unsigned CoordW  = 32;
  localparam int unsigned QuatW   = 16;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned ProdW   = 2 * QuatW;

  // matrix entries are Q.28 and need 34 bits signed
  localparam int unsigned EntFrac = 28;
  localparam int unsigned EntW    = 34;

  // coordinate split into a signed upper half and an unsigned lower half
  localparam int unsigned HalfW = CoordW / 2;
  localparam int unsigned PhW   = EntW + HalfW;
  localparam int unsigned PlW   = EntW + HalfW + 1;
  localparam int unsigned ShW   = PhW + 2;
  localparam int unsigned SlW   = PlW + 2;
  localparam int unsigned TotW  = ShW + HalfW + 2;
  localparam int unsigned RndW  = TotW - EntFrac;

  localparam int unsigned NumAxes  = 3;
  localparam int unsigned NumLanes = 2 * NumAxes;

  typedef logic signed [CoordW-1:0] qbbr_coord_t;
  typedef logic signed [QuatW-1:0]  qbbr_quat_t;
  typedef logic signed [ProdW-1:0]  qbbr_prod_t;
  typedef logic signed [EntW-1:0]   qbbr_ent_t;
  typedef logic signed [PhW-1:0]    qbbr_ph_t;
  typedef logic signed [PlW-1:0]    qbbr_pl_t;
  typedef logic signed [ShW-1:0]    qbbr_sh_t;
  typedef logic signed [SlW-1:0]    qbbr_sl_t;
  typedef logic signed [TotW-1:0]   qbbr_tot_t;
  typedef logic signed [RndW-1:0]   qbbr_rnd_t;

  // 1.0 in Q.28 and one half result lsb in the exact sum
  localparam qbbr_ent_t QOne      = qbbr_ent_t'(1) <<< EntFrac;
  localparam qbbr_tot_t RoundHalf = qbbr_tot_t'(1) <<< (EntFrac - 1);

  localparam qbbr_quat_t QuatRealRst = qbbr_quat_t'(16384);

  localparam qbbr_coord_t CoordMax = {1'b0, {(CoordW-1){1'b1}}};
  localparam qbbr_coord_t CoordMin = {1'b1, {(CoordW-1){1'b0}}};

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    QIDX_REAL = 8'd0,
    QIDX_I    = 8'd1,
    QIDX_J    = 8'd2,
    QIDX_K    = 8'd3
  } qbbr_cfg_idx_e;

  // per-stage load enables handed to every lane
  typedef struct packed {
    logic sel;
    logic mul;
    logic sum;
  } qbbr_lane_en_t;

endpackage

@@ design/qbbr_in_if.sv @@
// input box channel
interface qbbr_in_if;
  import qbbr_pkg::*;

  logic        valid;
  logic        ready;
  qbbr_coord_t in_x_low;
  qbbr_coord_t in_y_low;
  qbbr_coord_t in_z_low;
  qbbr_coord_t in_x_high;
  qbbr_coord_t in_y_high;
  qbbr_coord_t in_z_high;

  modport source (
    output valid, in_x_low, in_y_low, in_z_low, in_x_high, in_y_high, in_z_high,
    input  ready
  );
  modport sink (
    input  valid, in_x_low, in_y_low, in_z_low, in_x_high, in_y_high, in_z_high,
    output ready
  );
endinterface

@@ design/qbbr_out_if.sv @@
// output box channel
interface qbbr_out_if;
  import qbbr_pkg::*;

  logic        valid;
  logic        ready;
  qbbr_coord_t out_x_low;
  qbbr_coord_t out_y_low;
  qbbr_coord_t out_z_low;
  qbbr_coord_t out_x_high;
  qbbr_coord_t out_y_high;
  qbbr_coord_t out_z_high;

  modport source (
    output valid, out_x_low, out_y_low, out_z_low, out_x_high, out_y_high, out_z_high,
    input  ready
  );
  modport sink (
    input  valid, out_x_low, out_y_low, out_z_low, out_x_high, out_y_high, out_z_high,
    output ready
  );
endinterface

@@ design/qbbr_cfg_if.sv @@
// configuration write channel
interface qbbr_cfg_if;
  import qbbr_pkg::*;

  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [QuatW-1:0]   data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

@@ design/qbbr_matrix.sv @@
// quaternion registers and the rotation matrix derived from them
module qbbr_matrix import qbbr_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  qbbr_cfg_if.sink      cfg_i,
  output logic          pos_o [NumAxes][NumAxes],
  output qbbr_ent_t     mat_o [NumAxes][NumAxes]
);

  qbbr_quat_t qr_q, qi_q, qj_q, qk_q;
  qbbr_prod_t pii_q, pij_q, pik_q, pir_q, pjj_q, pjk_q, pjr_q, pkk_q, pkr_q;
  qbbr_ent_t  mat_d [NumAxes][NumAxes];
  qbbr_ent_t  mat_q [NumAxes][NumAxes];

  // writes are always taken
  assign cfg_i.ready = 1'b1;

  // quaternion registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qr_q <= QuatRealRst;
      qi_q <= '0;
      qj_q <= '0;
      qk_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (qbbr_cfg_idx_e'(cfg_i.index))
        QIDX_REAL: qr_q <= qbbr_quat_t'(cfg_i.data);
        QIDX_I:    qi_q <= qbbr_quat_t'(cfg_i.data);
        QIDX_J:    qj_q <= qbbr_quat_t'(cfg_i.data);
        QIDX_K:    qk_q <= qbbr_quat_t'(cfg_i.data);
        default: ;
      endcase
    end
  end

  // pairwise component products, one multiplier each
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pii_q <= '0;
      pij_q <= '0;
      pik_q <= '0;
      pir_q <= '0;
      pjj_q <= '0;
      pjk_q <= '0;
      pjr_q <= '0;
      pkk_q <= '0;
      pkr_q <= '0;
    end else begin
      pii_q <= qi_q * qi_q;
      pij_q <= qi_q * qj_q;
      pik_q <= qi_q * qk_q;
      pir_q <= qi_q * qr_q;
      pjj_q <= qj_q * qj_q;
      pjk_q <= qj_q * qk_q;
      pjr_q <= qj_q * qr_q;
      pkk_q <= qk_q * qk_q;
      pkr_q <= qk_q * qr_q;
    end
  end

  // matrix entries in Q.28, row = output axis, column = input axis
  always_comb begin
    mat_d[0][0] = QOne - ((EntW'(pjj_q) + EntW'(pkk_q)) <<< 1);
    mat_d[0][1] = (EntW'(pij_q) - EntW'(pkr_q)) <<< 1;
    mat_d[0][2] = (EntW'(pik_q) + EntW'(pjr_q)) <<< 1;
    mat_d[1][0] = (EntW'(pij_q) + EntW'(pkr_q)) <<< 1;
    mat_d[1][1] = QOne - ((EntW'(pii_q) + EntW'(pkk_q)) <<< 1);
    mat_d[1][2] = (EntW'(pjk_q) - EntW'(pir_q)) <<< 1;
    mat_d[2][0] = (EntW'(pik_q) - EntW'(pjr_q)) <<< 1;
    mat_d[2][1] = (EntW'(pjk_q) + EntW'(pir_q)) <<< 1;
    mat_d[2][2] = QOne - ((EntW'(pii_q) + EntW'(pjj_q)) <<< 1);
  end

  // registered matrix, identity after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NumAxes; r++) begin
        for (int c = 0; c < NumAxes; c++) begin
          mat_q[r][c] <= (r == c) ? QOne : '0;
        end
      end
    end else begin
      mat_q <= mat_d;
    end
  end

  // entry signs pick the bounds one stage ahead of the multipliers
  always_comb begin
    for (int r = 0; r < NumAxes; r++) begin
      for (int c = 0; c < NumAxes; c++) begin
        pos_o[r][c] = (mat_d[r][c] > 0);
      end
    end
  end

  assign mat_o = mat_q;

endmodule

@@ design/qbbr_lane.sv @@
// one output bound: bound selection, split multiplies, sums, rounding and clamp
module qbbr_lane import qbbr_pkg::*; (
  input  logic          clk_i,
  input  qbbr_lane_en_t en_i,
  input  logic          want_high_i,
  input  logic          pos_i [NumAxes],
  input  qbbr_ent_t     row_i [NumAxes],
  input  qbbr_coord_t   lo_i [NumAxes],
  input  qbbr_coord_t   hi_i [NumAxes],
  output qbbr_coord_t   bound_o
);

  qbbr_coord_t c_d [NumAxes];
  qbbr_coord_t c_q [NumAxes];
  qbbr_ph_t    ph_d [NumAxes];
  qbbr_ph_t    ph_q [NumAxes];
  qbbr_pl_t    pl_d [NumAxes];
  qbbr_pl_t    pl_q [NumAxes];
  qbbr_sh_t    sh_d, sh_q;
  qbbr_sl_t    sl_d, sl_q;
  qbbr_tot_t   tot;
  qbbr_rnd_t   rnd;

  // pick low or high per input axis from the entry sign
  always_comb begin
    for (int n = 0; n < NumAxes; n++) begin
      c_d[n] = (pos_i[n] ^ want_high_i) ? lo_i[n] : hi_i[n];
    end
  end

  // entry times upper signed half and lower unsigned half
  always_comb begin
    for (int n = 0; n < NumAxes; n++) begin
      ph_d[n] = row_i[n] * $signed(c_q[n][CoordW-1:HalfW]);
      pl_d[n] = row_i[n] * $signed({1'b0, c_q[n][HalfW-1:0]});
    end
  end

  // partial sums over the three axes
  always_comb begin
    sh_d = ShW'(ph_q[0]) + ShW'(ph_q[1]) + ShW'(ph_q[2]);
    sl_d = SlW'(pl_q[0]) + SlW'(pl_q[1]) + SlW'(pl_q[2]);
  end

  // pipeline registers
  always_ff @(posedge clk_i) begin
    if (en_i.sel) begin
      c_q <= c_d;
    end
    if (en_i.mul) begin
      ph_q <= ph_d;
      pl_q <= pl_d;
    end
    if (en_i.sum) begin
      sh_q <= sh_d;
      sl_q <= sl_d;
    end
  end

  // exact sum, round half up to Q16.16, clamp to 32 bits
  always_comb begin
    tot = (TotW'(sh_q) <<< HalfW) + TotW'(sl_q) + RoundHalf;
    rnd = $signed(tot[TotW-1:EntFrac]);
    if ((&rnd[RndW-1:CoordW-1]) || !(|rnd[RndW-1:CoordW-1])) begin
      bound_o = rnd[CoordW-1:0];
    end else begin
      bound_o = rnd[RndW-1] ? CoordMin : CoordMax;
    end
  end

endmodule

@@ design/quaternion_box_bounds_rotate.sv @@
// top level: bounds of an axis-aligned box after quaternion rotation
//
// Channels: in_i takes one box per transaction (low and high bound per axis,
// Q16.16), out_o returns the rotated bounds, one transaction per box, in order.
// cfg_i writes the quaternion (index 0 real, 1..3 i, j, k, Q2.14); it is always
// ready and writes to other indexes are dropped. Write it while no box is in
// flight; a box may follow in the very next cycle.
// Stages: swap, bound select, multiply, sum, round/clamp into output register.
// Throughput: one box per cycle while out_o is not stalled. Six lanes, one
// per output bound, each with three 34x16 and three 34x17 multipliers, run
// side by side and the output register gathers their results.
// Reset: the quaternion returns to 1 + 0i + 0j + 0k (identity rotation) and
// the pipeline empties.
// Stall: when out_o is not ready the result holds; boxes keep entering until
// every stage behind the output register is full, then in_i.ready drops.
module quaternion_box_bounds_rotate import qbbr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  qbbr_in_if.sink   in_i,
  qbbr_out_if.source out_o,
  qbbr_cfg_if.sink  cfg_i
);

  logic          pos [NumAxes][NumAxes];
  qbbr_ent_t     mat [NumAxes][NumAxes];
  qbbr_coord_t   in_a [NumAxes];
  qbbr_coord_t   in_b [NumAxes];
  qbbr_coord_t   lo1_q [NumAxes];
  qbbr_coord_t   hi1_q [NumAxes];
  qbbr_coord_t   bound [NumLanes];
  qbbr_coord_t   out_q [NumLanes];
  logic          v1_q, v2_q, v3_q, v4_q, ov_q;
  logic          adv1, adv2, adv3, adv4, adv_o;
  qbbr_lane_en_t lane_en;

  // quaternion registers and matrix
  qbbr_matrix u_matrix (
    .clk_i,
    .rst_ni,
    .cfg_i,
    .pos_o (pos),
    .mat_o (mat)
  );

  // a stage moves when it is empty or the next one moves
  always_comb begin
    adv_o = !ov_q || out_o.ready;
    adv4  = !v4_q || adv_o;
    adv3  = !v3_q || adv4;
    adv2  = !v2_q || adv3;
    adv1  = !v1_q || adv2;
    lane_en.sel = adv2;
    lane_en.mul = adv3;
    lane_en.sum = adv4;
  end

  assign in_i.ready = adv1;

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (adv1)  v1_q <= in_i.valid;
      if (adv2)  v2_q <= v1_q;
      if (adv3)  v3_q <= v2_q;
      if (adv4)  v4_q <= v3_q;
      if (adv_o) ov_q <= v4_q;
    end
  end

  // order each axis pair so low does not exceed high
  always_comb begin
    in_a[0] = in_i.in_x_low;
    in_a[1] = in_i.in_y_low;
    in_a[2] = in_i.in_z_low;
    in_b[0] = in_i.in_x_high;
    in_b[1] = in_i.in_y_high;
    in_b[2] = in_i.in_z_high;
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      for (int n = 0; n < NumAxes; n++) begin
        lo1_q[n] <= (in_a[n] > in_b[n]) ? in_b[n] : in_a[n];
        hi1_q[n] <= (in_a[n] > in_b[n]) ? in_a[n] : in_b[n];
      end
    end
  end

  // lanes: low bounds of x, y, z then high bounds of x, y, z
  for (genvar l = 0; l < NumLanes; l++) begin : g_lane
    localparam int unsigned Row      = l % NumAxes;
    localparam logic        WantHigh = (l >= NumAxes);

    qbbr_lane u_lane (
      .clk_i,
      .en_i        (lane_en),
      .want_high_i (WantHigh),
      .pos_i       (pos[Row]),
      .row_i       (mat[Row]),
      .lo_i        (lo1_q),
      .hi_i        (hi1_q),
      .bound_o     (bound[l])
    );
  end

  // output register gathers the lane results
  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      out_q <= bound;
    end
  end

  assign out_o.valid      = ov_q;
  assign out_o.out_x_low  = out_q[0];
  assign out_o.out_y_low  = out_q[1];
  assign out_o.out_z_low  = out_q[2];
  assign out_o.out_x_high = out_q[3];
  assign out_o.out_y_high = out_q[4];
  assign out_o.out_z_high = out_q[5];

endmodule

@@ design/qbbr_checker.sv @@
// port-level assertions for the rotated box bounds block, bound to the top level
module qbbr_checker import qbbr_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        cfg_ready_i,
  input qbbr_coord_t out_x_low_i,
  input qbbr_coord_t out_y_low_i,
  input qbbr_coord_t out_z_low_i,
  input qbbr_coord_t out_x_high_i,
  input qbbr_coord_t out_y_high_i,
  input qbbr_coord_t out_z_high_i
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_x_low_i) &&
      $stable(out_y_low_i) && $stable(out_z_low_i) && $stable(out_x_high_i) &&
      $stable(out_y_high_i) && $stable(out_z_high_i))
    else $error("stalled output transaction changed");

  // nothing leaves right after reset
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("output valid right after reset");

  // with the output register empty the whole pipeline can move
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled while output register empty");

  // configuration writes are never refused
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_i)
    else $error("configuration channel not ready");

  // an unstalled box shows up at the output once it has passed the pipeline
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(in_valid_i && in_ready_i, 5) && $past(out_ready_i, 1) &&
      $past(out_ready_i, 2) && $past(out_ready_i, 3) && $past(out_ready_i, 4) &&
      $past(rst_ni, 1) && $past(rst_ni, 2) && $past(rst_ni, 3) &&
      $past(rst_ni, 4) && $past(rst_ni, 5) |-> out_valid_i)
    else $error("result missing after pipeline latency");

endmodule

bind quaternion_box_bounds_rotate qbbr_checker u_qbbr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .cfg_ready_i  (cfg_i.ready),
  .out_x_low_i  (out_o.out_x_low),
  .out_y_low_i  (out_o.out_y_low),
  .out_z_low_i  (out_o.out_z_low),
  .out_x_high_i (out_o.out_x_high),
  .out_y_high_i (out_o.out_y_high),
  .out_z_high_i (out_o.out_z_high)
);
